### rtl/dtmfcpt_pkg.sv
// Shared types, tone and cadence tables, and the build-time oscillator ROM math
// for the DTMF / call-progress tone generator. No dependencies.
`timescale 1ns / 1ps
package dtmfcpt_pkg;

  localparam int NUM_TONES    = 19;
  localparam int NUM_PATTERNS = 26;
  localparam int OSC_W        = 18;
  localparam int TONE_W       = 5;
  localparam int IDX_W        = 3;
  localparam int MS_W         = 12;
  localparam int DUR_W        = 22;
  localparam int ELAPSED_W    = 23;

  // item modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  // patterns with special handling
  localparam logic [4:0] PAT_DIAL      = 5'd16;
  localparam logic [4:0] PAT_BUSY      = 5'd17;
  localparam logic [4:0] PAT_RINGBACK  = 5'd18;
  localparam logic [4:0] PAT_FAILED    = 5'd20;
  localparam logic [4:0] PAT_BACKSPACE = 5'd22;
  localparam logic [4:0] PAT_WAITING   = 5'd23;

  // locales
  localparam logic [2:0] LOC_DE = 3'd1;
  localparam logic [2:0] LOC_FR = 3'd2;
  localparam logic [2:0] LOC_GB = 3'd3;
  localparam logic [2:0] LOC_IL = 3'd4;
  localparam logic [2:0] LOC_NL = 3'd5;

  // tone numbers; 0 means no tone
  localparam logic [4:0] TN     = 5'd0;
  localparam logic [4:0] T350   = 5'd1;
  localparam logic [4:0] T400   = 5'd2;
  localparam logic [4:0] T425   = 5'd3;
  localparam logic [4:0] T440   = 5'd4;
  localparam logic [4:0] T450   = 5'd5;
  localparam logic [4:0] T480   = 5'd6;
  localparam logic [4:0] T480L  = 5'd7;
  localparam logic [4:0] T620   = 5'd8;
  localparam logic [4:0] T620L  = 5'd9;
  localparam logic [4:0] T697   = 5'd10;
  localparam logic [4:0] T770   = 5'd11;
  localparam logic [4:0] T852   = 5'd12;
  localparam logic [4:0] T941   = 5'd13;
  localparam logic [4:0] T1209H = 5'd14;
  localparam logic [4:0] T1209L = 5'd15;
  localparam logic [4:0] T1336  = 5'd16;
  localparam logic [4:0] T1477H = 5'd17;
  localparam logic [4:0] T1477L = 5'd18;
  localparam logic [4:0] T1633  = 5'd19;

  typedef struct packed {
    logic [TONE_W-1:0] lo;
    logic [TONE_W-1:0] hi;
    logic [MS_W-1:0]   ms;
  } seg_t;

  typedef struct packed {
    logic              mul;
    logic              upd;
    logic [TONE_W-1:0] tone;
  } osc_cmd_t;

  typedef logic signed [OSC_W-1:0] rom_t [NUM_TONES];

  localparam int TONE_HZ [NUM_TONES] = '{350, 400, 425, 440, 450, 480, 480, 620, 620, 697,
                                         770, 852, 941, 1209, 1209, 1336, 1477, 1477, 1633};
  localparam int TONE_AMP [NUM_TONES] = '{0, 0, 0, 0, 0, 0, 1, 0, 1, 3, 3, 3, 3, 2, 4, 4,
                                          2, 4, 4};
  localparam longint AMP_MANT [5] = '{13421773, 15938355, 15770583, 13042608, 9210692};
  localparam int AMP_EXP [5] = '{26, 24, 25, 27, 26};

  function automatic seg_t mk(logic [4:0] lo, logic [4:0] hi, int ms);
    seg_t s;
    s.lo = lo;
    s.hi = hi;
    s.ms = MS_W'(ms);
    return s;
  endfunction

  // two-slot cadence: tone on, then silence
  function automatic seg_t two(logic [IDX_W-1:0] idx, logic [4:0] lo, logic [4:0] hi,
                               int on, int off);
    seg_t s;
    s = '0;
    if (idx == 3'd0) s = mk(lo, hi, on);
    else if (idx == 3'd1) s = mk(TN, TN, off);
    return s;
  endfunction

  function automatic seg_t key_seg(logic [4:0] pat);
    seg_t s;
    unique case (pat)
      5'd1:    s = mk(T697, T1209L, 1000);
      5'd2:    s = mk(T697, T1336, 1000);
      5'd3:    s = mk(T697, T1477L, 1000);
      5'd4:    s = mk(T770, T1209L, 1000);
      5'd5:    s = mk(T770, T1336, 1000);
      5'd6:    s = mk(T770, T1477L, 1000);
      5'd7:    s = mk(T852, T1209L, 1000);
      5'd8:    s = mk(T852, T1336, 1000);
      5'd9:    s = mk(T852, T1477L, 1000);
      5'd10:   s = mk(T941, T1209L, 1000);
      5'd11:   s = mk(T941, T1477L, 1000);
      5'd12:   s = mk(T697, T1633, 1000);
      5'd13:   s = mk(T770, T1633, 1000);
      5'd14:   s = mk(T852, T1633, 1000);
      5'd15:   s = mk(T941, T1633, 1000);
      default: s = mk(T941, T1336, 1000);
    endcase
    return s;
  endfunction

  function automatic seg_t loc_seg(logic [4:0] pat, logic [IDX_W-1:0] idx, logic [2:0] loc);
    seg_t s;
    logic [4:0] t;
    int busy, ron, roff, fail;
    s = '0;
    t = T425; busy = 500; ron = 1000; roff = 4000; fail = 250;
    unique case (loc)
      LOC_DE:  begin busy = 480; fail = 240; end
      LOC_FR:  begin t = T440; ron = 1500; roff = 3500; end
      LOC_IL:  begin t = T400; roff = 3000; end
      default: ;
    endcase
    if (loc == LOC_GB) begin
      unique case (pat)
        PAT_DIAL: if (idx == 3'd0) s = mk(T350, T440, 1000);
        PAT_BUSY: s = two(idx, T400, TN, 375, 375);
        PAT_RINGBACK: begin
          unique case (idx)
            3'd0, 3'd2: s = mk(T400, T450, 400);
            3'd1:       s = mk(TN, TN, 200);
            3'd3:       s = mk(TN, TN, 2000);
            default:    s = '0;
          endcase
        end
        default: begin
          unique case (idx)
            3'd0:    s = mk(T400, TN, 400);
            3'd1:    s = mk(TN, TN, 350);
            3'd2:    s = mk(T400, TN, 225);
            3'd3:    s = mk(TN, TN, 525);
            default: s = '0;
          endcase
        end
      endcase
    end else begin
      unique case (pat)
        PAT_DIAL:     if (idx == 3'd0) s = mk(t, TN, 1000);
        PAT_BUSY:     s = two(idx, t, TN, busy, busy);
        PAT_RINGBACK: s = two(idx, t, TN, ron, roff);
        default:      s = two(idx, t, TN, fail, fail);
      endcase
    end
    return s;
  endfunction

  // cadence lookup for one segment; locales 6 and 7 fall back to the default set
  function automatic seg_t seg_at(logic [4:0] pat, logic [IDX_W-1:0] idx, logic [2:0] loc);
    seg_t s;
    logic loc_pat;
    s = '0;
    loc_pat = (pat == PAT_DIAL) || (pat == PAT_BUSY) || (pat == PAT_RINGBACK) ||
              (pat == PAT_FAILED);
    if (loc_pat && loc >= LOC_DE && loc <= LOC_NL) begin
      s = loc_seg(pat, idx, loc);
    end else if (pat < 5'd16) begin
      if (idx == 3'd0) s = key_seg(pat);
    end else begin
      unique case (pat)
        5'd16: if (idx == 3'd0) s = mk(T350, T440, 1000);
        5'd17: s = two(idx, T480, T620, 500, 500);
        5'd18: s = two(idx, T480, T440, 2000, 4000);
        5'd19: begin
          unique case (idx)
            3'd0:    s = mk(T1209H, TN, 500);
            3'd1:    s = mk(T1477H, TN, 500);
            3'd2:    s = mk(TN, TN, 2000);
            default: s = '0;
          endcase
        end
        5'd20: s = two(idx, T480, T620, 300, 200);
        5'd21: if (idx == 3'd0) s = mk(TN, TN, 1000);
        5'd22: if (idx == 3'd0) s = mk(T852, T1633, 50);
        5'd23: if (idx == 3'd0) s = mk(T941, T1633, 50);
        5'd24: begin
          unique case (idx)
            3'd0, 3'd2, 3'd4: s = mk(T480, T440, 200);
            3'd1, 3'd3:       s = mk(TN, TN, 150);
            3'd5:             s = mk(TN, TN, 1950);
            default:          s = '0;
          endcase
        end
        5'd25:   s = two(idx, T480L, T620L, 250, 250);
        default: if (idx == 3'd0) s = key_seg(5'd0);
      endcase
    end
    return s;
  endfunction

  // build-time helpers: 64-bit restoring division and Q60 multiply
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // coefficient (seed_sel 0) or seed (seed_sel 1) table for a sample rate
  function automatic rom_t build_rom(int sr, int frac, bit seed_sel);
    rom_t rom;
    logic [63:0] num, den, x, rm, x2, term, c, s, v;
    for (int t = 0; t < NUM_TONES; t++) begin
      num = 64'd62831852 * 64'(TONE_HZ[t]);
      den = 64'd10000000 * 64'(sr);
      x = udiv64(num, den);
      rm = num - x * den;
      for (int i = 0; i < 60; i++) begin
        rm = rm << 1;
        x = x << 1;
        if (rm >= den) begin
          rm = rm - den;
          x = x | 64'd1;
        end
      end
      x2 = qmul(x, x);
      c = 64'd1 << 60;
      term = c;
      for (int k = 1; k <= 20; k++) begin
        term = udiv64(qmul(term, x2), 64'((2 * k - 1) * (2 * k)));
        c = (k % 2 == 1) ? c - term : c + term;
      end
      s = x;
      term = x;
      for (int k = 1; k <= 20; k++) begin
        term = udiv64(qmul(term, x2), 64'((2 * k) * (2 * k + 1)));
        s = (k % 2 == 1) ? s - term : s + term;
      end
      if (seed_sel)
        v = ((s >> 22) * 64'(AMP_MANT[TONE_AMP[t]])) >> (23 + AMP_EXP[TONE_AMP[t]]);
      else
        v = c >> (59 - frac);
      rom[t] = v[OSC_W-1:0];
    end
    return rom;
  endfunction

endpackage

### rtl/dtmfcpt_osc.sv
// Bank of second-order recursive sine oscillators sharing one multiplier.
// Depends on dtmfcpt_pkg for the coefficient/seed ROM builder and command struct.
`timescale 1ns / 1ps
module dtmfcpt_osc #(
  parameter int SAMPLE_RATE         = 8000,
  parameter int COEFF_FRACTION_BITS = 14
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  dtmfcpt_pkg::osc_cmd_t                    cmd_i,
  output logic signed [dtmfcpt_pkg::OSC_W-1:0]     y_o
);
  import dtmfcpt_pkg::*;

  localparam int CW = COEFF_FRACTION_BITS + 2;
  localparam int PW = CW + OSC_W;
  localparam rom_t COEF = build_rom(SAMPLE_RATE, COEFF_FRACTION_BITS, 1'b0);
  localparam rom_t SEED = build_rom(SAMPLE_RATE, COEFF_FRACTION_BITS, 1'b1);

  logic signed [OSC_W-1:0] s1_q [NUM_TONES];
  logic signed [OSC_W-1:0] s2_q [NUM_TONES];
  logic signed [PW-1:0]    prod_q;
  logic signed [CW-1:0]    coef;
  logic signed [PW-1:0]    yw;

  assign coef = $signed(COEF[cmd_i.tone][CW-1:0]);
  assign yw   = (prod_q >>> COEFF_FRACTION_BITS) - PW'(s2_q[cmd_i.tone]);
  assign y_o  = yw[OSC_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) prod_q <= PW'(coef) * PW'(s1_q[cmd_i.tone]);
  end

  // state wraps at 18 bits; advance the one tone named by the command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TONES; i++) begin
        s1_q[i] <= SEED[i];
        s2_q[i] <= '0;
      end
    end else if (cmd_i.upd) begin
      s2_q[cmd_i.tone] <= s1_q[cmd_i.tone];
      s1_q[cmd_i.tone] <= yw[OSC_W-1:0];
    end
  end

endmodule

### rtl/dtmf_call_progress_tone_generator_core.sv
// Top level of the DTMF / call-progress tone generator: cadence sequencer,
// output register and stream ports. Depends on dtmfcpt_pkg and dtmfcpt_osc.
//
// channel   direction  payload
// s_axis    in         tdata: mode[1:0], tone_select[6:2]
// m_axis    out        tdata: sample[15:0], playing[16], pattern_ended[17]; tuser: sample_valid
// cfg       in         cfg_data_i: locale_select[2:0]
//
// Start, stop and idle ticks post their result straight from the accept. An active tick
// passes an accept step, a lookup per segment (skipped segments included) and a
// multiply and an update step per tone on the shared multiplier. Not ready while an
// item is in work or its result waits. Reset clears the sequencer and reloads the
// oscillator seeds.
`timescale 1ns / 1ps
module dtmf_call_progress_tone_generator_core #(
  parameter int SAMPLE_RATE          = 8000,
  parameter int SEGMENTS_PER_PATTERN = 6,
  parameter int COEFF_FRACTION_BITS  = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // mode[1:0], tone_select[6:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // sample[15:0], playing[16], pattern_ended[17]
  output logic        m_axis_tuser,   // sample_valid
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i      // locale_select
);
  import dtmfcpt_pkg::*;

  localparam int US_PER_SAMPLE = (1000000 + SAMPLE_RATE / 2) / SAMPLE_RATE;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_MLO  = 3'd2;
  localparam logic [2:0] S_ALO  = 3'd3;
  localparam logic [2:0] S_MHI  = 3'd4;
  localparam logic [2:0] S_AHI  = 3'd5;

  logic [2:0]           state_q;
  logic [2:0]           loc_q;
  logic                 active_q;
  logic [4:0]           pat_q;
  logic [IDX_W-1:0]     idx_q;
  logic [ELAPSED_W-1:0] elapsed_q;
  logic [TONE_W-1:0]    lo_q, hi_q;
  logic signed [18:0]   acc_q;
  logic                 out_valid_q;
  logic [15:0]          sample_q;
  logic                 svalid_q, play_q, ended_q;

  logic [1:0]           mode;
  logic [4:0]           sel;
  seg_t                 seg;
  logic [DUR_W-1:0]     dur;
  logic                 fits;
  logic [IDX_W:0]       nidx;
  logic                 wrap;
  osc_cmd_t             cmd;
  logic signed [OSC_W-1:0] y;
  logic signed [18:0]   sum;
  logic [15:0]          sat;

  assign mode = s_axis_tdata[1:0];
  assign sel  = s_axis_tdata[6:2];

  assign seg  = seg_at(pat_q, idx_q, loc_q);
  assign dur  = DUR_W'(seg.ms) * DUR_W'(1000);
  assign fits = ({1'b0, elapsed_q} + (ELAPSED_W + 1)'(US_PER_SAMPLE)) <= (ELAPSED_W + 1)'(dur);
  assign nidx = {1'b0, idx_q} + 1'b1;
  assign wrap = nidx >= (IDX_W + 1)'(SEGMENTS_PER_PATTERN);

  assign cmd.mul  = (state_q == S_MLO) || (state_q == S_MHI);
  assign cmd.upd  = (state_q == S_ALO) || (state_q == S_AHI);
  assign cmd.tone = ((state_q == S_MHI) || (state_q == S_AHI)) ? hi_q - 1'b1 : lo_q - 1'b1;

  dtmfcpt_osc #(
    .SAMPLE_RATE        (SAMPLE_RATE),
    .COEFF_FRACTION_BITS(COEFF_FRACTION_BITS)
  ) u_osc (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .y_o   (y)
  );

  assign sum = acc_q + 19'(y);
  always_comb begin
    priority if (sum > 19'sd32767)  sat = 16'h7FFF;
    else if (sum < -19'sd32767)     sat = 16'h8001;
    else                            sat = sum[15:0];
  end

  assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, ended_q, play_q, sample_q};
  assign m_axis_tuser  = svalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_q <= '0;
    end else if (cfg_valid_i) begin
      loc_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOOK) begin
      lo_q <= seg.lo;
      hi_q <= seg.hi;
    end
    if (state_q == S_ALO) acc_q <= 19'(y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      pat_q       <= '0;
      idx_q       <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
      svalid_q    <= 1'b0;
      play_q      <= 1'b0;
      ended_q     <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            sample_q <= '0;
            svalid_q <= 1'b0;
            ended_q  <= 1'b0;
            play_q   <= active_q;
            if (mode == MODE_START && sel < 5'(NUM_PATTERNS)) begin
              active_q    <= 1'b1;
              pat_q       <= sel;
              idx_q       <= '0;
              elapsed_q   <= '0;
              play_q      <= 1'b1;
              out_valid_q <= 1'b1;
            end else if (mode == MODE_START || mode == MODE_STOP) begin
              active_q    <= 1'b0;
              play_q      <= 1'b0;
              out_valid_q <= 1'b1;
            end else if (mode == MODE_TICK) begin
              svalid_q <= 1'b1;
              if (active_q) state_q <= S_LOOK;
              else out_valid_q <= 1'b1;
            end else begin
              out_valid_q <= 1'b1;
            end
          end
        end
        S_LOOK: begin
          if (fits) begin
            elapsed_q <= elapsed_q + ELAPSED_W'(US_PER_SAMPLE);
            if (seg.lo == TN) begin
              play_q      <= 1'b1;
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end else begin
              state_q <= S_MLO;
            end
          end else begin
            // skip a finished or empty segment
            elapsed_q <= '0;
            if (!wrap) begin
              idx_q <= nidx[IDX_W-1:0];
            end else if (pat_q == PAT_BACKSPACE || pat_q == PAT_WAITING) begin
              idx_q       <= nidx[IDX_W-1:0];
              active_q    <= 1'b0;
              play_q      <= 1'b0;
              ended_q     <= 1'b1;
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end else begin
              idx_q <= '0;
            end
          end
        end
        S_MLO: state_q <= S_ALO;
        S_ALO: begin
          if (hi_q == TN) begin
            sample_q    <= y[15:0];
            play_q      <= 1'b1;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_MHI;
          end
        end
        S_MHI: state_q <= S_AHI;
        S_AHI: begin
          sample_q    <= sat;
          play_q      <= 1'b1;
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) != S_IDLE) ||
                           $past(s_axis_tvalid && s_axis_tready))
    else $error("result without an accepted item");

  a_look_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |-> active_q)
    else $error("cadence walk while no pattern is active");

  a_nontick_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !svalid_q) |-> (sample_q == 16'd0))
    else $error("nonzero sample on a non-tick result");

  a_ended_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ended_q) |-> (!play_q && !active_q))
    else $error("pattern ended but still playing");

endmodule

### dv/tb_dtmf_call_progress_tone_generator_core.sv
// Self-checking testbench for dtmf_call_progress_tone_generator_core: drives tick, start,
// stop and unused-mode items with random gaps and stalls, predicts every result in a
// scoreboard class. Depends on dtmfcpt_pkg and the RTL of the tone generator.
`timescale 1ns / 1ps
module tb_dtmf_call_progress_tone_generator_core;
  import dtmfcpt_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int US_PER_TICK = 125;   // 8 kHz sample period
  localparam int SEGS = 6;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int COEFF_FRACTION_BITS_TB = 14;

  localparam int HZ  [NUM_TONES] = '{350, 400, 425, 440, 450, 480, 480, 620, 620, 697,
                                     770, 852, 941, 1209, 1209, 1336, 1477, 1477, 1633};
  localparam int AMPC [NUM_TONES] = '{0, 0, 0, 0, 0, 0, 1, 0, 1, 3, 3, 3, 3, 2, 4, 4, 2, 4, 4};
  localparam longint MANT [5] = '{13421773, 15938355, 15770583, 13042608, 9210692};
  localparam int EXPO [5] = '{26, 24, 25, 27, 26};
  // key rows and columns for patterns 0..15
  localparam int KEY_LO [16] = '{13, 10, 10, 10, 11, 11, 11, 12, 12, 12, 13, 13, 10, 11, 12, 13};
  localparam int KEY_HI [16] = '{16, 15, 16, 18, 15, 16, 18, 15, 16, 18, 15, 18, 19, 19, 19, 19};

  typedef struct {
    int lo;
    int hi;
    int ms;
  } cadence_t;

  typedef struct {
    logic [15:0] sample;
    logic        sample_valid;
    logic        playing;
    logic        pattern_ended;
  } tone_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // mode[1:0], tone_select[6:2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // sample[15:0], playing[16], pattern_ended[17]
  logic        m_axis_tuser;         // sample_valid
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_data_i = '0;

  class tone_scoreboard;
    tone_out_t          pending_q[$];
    int                 errors;
    int                 ends_seen;
    int                 ticks_sounding;
    int                 coeff [NUM_TONES];
    logic signed [17:0] s1 [NUM_TONES];
    logic signed [17:0] s2 [NUM_TONES];
    logic [2:0]         locale;
    bit                 active;
    int                 pattern;
    int                 seg_idx;
    int                 elapsed_us;

    function logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
    endfunction

    function new();
      logic [63:0] num, den, x, r, x2, term, c, s, v;
      for (int t = 0; t < NUM_TONES; t++) begin
        num = 64'd62831852 * 64'(HZ[t]);
        den = 64'd80000000000;
        x = num / den;
        r = num % den;
        for (int i = 0; i < 60; i++) begin
          r = r << 1;
          x = x << 1;
          if (r >= den) begin
            r = r - den;
            x = x | 64'd1;
          end
        end
        x2 = mul_q60(x, x);
        c = 64'd1 << 60;
        term = c;
        for (int k = 1; k <= 20; k++) begin
          term = mul_q60(term, x2) / 64'((2 * k - 1) * (2 * k));
          c = k[0] ? c - term : c + term;
        end
        s = x;
        term = x;
        for (int k = 1; k <= 20; k++) begin
          term = mul_q60(term, x2) / 64'((2 * k) * (2 * k + 1));
          s = k[0] ? s - term : s + term;
        end
        coeff[t] = int'(c >> 45);
        v = ((s >> 22) * 64'(MANT[AMPC[t]])) >> (23 + EXPO[AMPC[t]]);
        s1[t] = v[17:0];
        s2[t] = '0;
      end
      locale = '0;
      active = 0;
      pattern = 0;
      seg_idx = 0;
      elapsed_us = 0;
      errors = 0;
      ends_seen = 0;
      ticks_sounding = 0;
    endfunction

    function cadence_t cad(int lo, int hi, int ms);
      cadence_t k;
      k.lo = lo;
      k.hi = hi;
      k.ms = ms;
      return k;
    endfunction

    // tone on for slot 0, silence for slot 1
    function cadence_t on_off(int idx, int lo, int hi, int on_ms, int off_ms);
      if (idx == 0) return cad(lo, hi, on_ms);
      if (idx == 1) return cad(0, 0, off_ms);
      return cad(0, 0, 0);
    endfunction

    function cadence_t lookup(int pat, int idx);
      int t, busy, ron, roff, fail;
      bit by_locale;
      by_locale = (pat == PAT_DIAL || pat == PAT_BUSY || pat == PAT_RINGBACK ||
                   pat == PAT_FAILED) && locale >= LOC_DE && locale <= LOC_NL;
      if (by_locale && locale == LOC_GB) begin
        case (pat)
          PAT_DIAL: return (idx == 0) ? cad(T350, T440, 1000) : cad(0, 0, 0);
          PAT_BUSY: return on_off(idx, T400, 0, 375, 375);
          PAT_RINGBACK: begin
            case (idx)
              0, 2: return cad(T400, T450, 400);
              1: return cad(0, 0, 200);
              3: return cad(0, 0, 2000);
              default: return cad(0, 0, 0);
            endcase
          end
          default: begin
            case (idx)
              0: return cad(T400, 0, 400);
              1: return cad(0, 0, 350);
              2: return cad(T400, 0, 225);
              3: return cad(0, 0, 525);
              default: return cad(0, 0, 0);
            endcase
          end
        endcase
      end
      if (by_locale) begin
        t = T425; busy = 500; ron = 1000; roff = 4000; fail = 250;
        if (locale == LOC_DE) begin busy = 480; fail = 240; end
        if (locale == LOC_FR) begin t = T440; ron = 1500; roff = 3500; end
        if (locale == LOC_IL) begin t = T400; roff = 3000; end
        case (pat)
          PAT_DIAL: return (idx == 0) ? cad(t, 0, 1000) : cad(0, 0, 0);
          PAT_BUSY: return on_off(idx, t, 0, busy, busy);
          PAT_RINGBACK: return on_off(idx, t, 0, ron, roff);
          default: return on_off(idx, t, 0, fail, fail);
        endcase
      end
      if (pat < 16) return (idx == 0) ? cad(KEY_LO[pat], KEY_HI[pat], 1000) : cad(0, 0, 0);
      case (pat)
        16: return (idx == 0) ? cad(T350, T440, 1000) : cad(0, 0, 0);
        17: return on_off(idx, T480, T620, 500, 500);
        18: return on_off(idx, T480, T440, 2000, 4000);
        19: begin
          case (idx)
            0: return cad(T1209H, 0, 500);
            1: return cad(T1477H, 0, 500);
            2: return cad(0, 0, 2000);
            default: return cad(0, 0, 0);
          endcase
        end
        20: return on_off(idx, T480, T620, 300, 200);
        21: return (idx == 0) ? cad(0, 0, 1000) : cad(0, 0, 0);
        22: return (idx == 0) ? cad(T852, T1633, 50) : cad(0, 0, 0);
        23: return (idx == 0) ? cad(T941, T1633, 50) : cad(0, 0, 0);
        24: begin
          case (idx)
            0, 2, 4: return cad(T480, T440, 200);
            1, 3: return cad(0, 0, 150);
            5: return cad(0, 0, 1950);
            default: return cad(0, 0, 0);
          endcase
        end
        default: return on_off(idx, T480L, T620L, 250, 250);
      endcase
    endfunction

    function longint step_osc(int t);
      longint p, y;
      logic signed [17:0] w;
      p = longint'(coeff[t]) * longint'(s1[t]);
      y = (p >>> COEFF_FRACTION_BITS_TB) - longint'(s2[t]);
      w = y[17:0];
      s2[t] = s1[t];
      s1[t] = w;
      return longint'(w);
    endfunction

    function logic [15:0] tone_sample(cadence_t k);
      longint z;
      if (k.lo == 0) return '0;
      if (k.hi == 0) begin
        z = step_osc(k.lo - 1);
        return z[15:0];
      end
      z = step_osc(k.lo - 1);
      z += step_osc(k.hi - 1);
      if (z > 32767) z = 32767;
      if (z < -32767) z = -32767;
      return z[15:0];
    endfunction

    function void set_locale(logic [2:0] loc);
      locale = loc;
    endfunction

    function void note(logic [1:0] mode, logic [4:0] sel);
      tone_out_t e;
      cadence_t k;
      int dur;
      e.sample = '0;
      e.sample_valid = 1'b0;
      e.pattern_ended = 1'b0;
      if (mode == MODE_START && sel < NUM_PATTERNS) begin
        active = 1;
        pattern = sel;
        seg_idx = 0;
        elapsed_us = 0;
      end else if (mode == MODE_START || mode == MODE_STOP) begin
        active = 0;
      end else if (mode == MODE_TICK) begin
        e.sample_valid = 1'b1;
        for (int g = 0; active && g < 18; g++) begin
          k = lookup(pattern, seg_idx);
          dur = k.ms * 1000;
          if (elapsed_us <= dur && dur - elapsed_us >= US_PER_TICK) begin
            e.sample = tone_sample(k);
            if (k.lo != 0) ticks_sounding++;
            elapsed_us += US_PER_TICK;
            break;
          end
          seg_idx++;
          if (seg_idx >= SEGS) begin
            if (pattern == PAT_BACKSPACE || pattern == PAT_WAITING) begin
              active = 0;
              e.pattern_ended = 1'b1;
              break;
            end
            seg_idx = 0;
          end
          elapsed_us = 0;
        end
      end
      e.playing = active;
      pending_q.push_back(e);
    endfunction

    function void check(logic [23:0] d, logic u);
      tone_out_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result: tdata %h tuser %b", d, u);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (d[15:0] !== e.sample) begin
        $error("sample: expected %0d, actual %0d", $signed(e.sample), $signed(d[15:0]));
        errors++;
      end
      if (u !== e.sample_valid) begin
        $error("sample_valid: expected %b, actual %b", e.sample_valid, u);
        errors++;
      end
      if (d[16] !== e.playing) begin
        $error("playing: expected %b, actual %b", e.playing, d[16]);
        errors++;
      end
      if (d[17] !== e.pattern_ended) begin
        $error("pattern_ended: expected %b, actual %b", e.pattern_ended, d[17]);
        errors++;
      end
      if (e.pattern_ended) ends_seen++;
    endfunction
  endclass

  tone_scoreboard sb;
  int  cycles = 0;
  int  items_sent = 0;
  int  hold_req = 0;
  bit  steady_ready = 0;

  dtmf_call_progress_tone_generator_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // sample at the falling edge: the item moves at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tuser);
  end

  // receiver: random stalls, steady stretches, and one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) steady_ready = !steady_ready;
        if ($urandom_range(0, 199) == 0) hold = $urandom_range(30, 80);
        m_axis_tready <= steady_ready || ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [4:0] sel);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, sel, mode};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    sb.note(mode, sel);
    items_sent++;
    gap = 0;
    if ($urandom_range(0, 49) == 0) gap = $urandom_range(20, 60);
    else if ($urandom_range(0, 7) == 0) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_locale(input logic [2:0] loc);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= loc;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_locale(loc);
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_item(MODE_TICK, 5'($urandom_range(0, 31)));
  endtask

  initial begin
    logic [2:0] locales [8];
    int pat, len, budget;
    locales = '{3'd0, 3'd5, 3'd1, 3'd2, 3'd3, 3'd4, 3'd7, 3'd6};
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle tick, unused mode, invalid start, extreme keys, single tones, stop
    send_item(MODE_TICK, 5'd31);
    send_item(MODE_UNUSED, 5'd0);
    send_item(MODE_START, 5'd31);
    send_item(MODE_TICK, 5'd0);
    send_item(MODE_START, 5'd0);
    run_ticks(3);
    send_item(MODE_START, 5'd15);
    run_ticks(2);
    send_item(MODE_UNUSED, 5'd31);
    send_item(MODE_START, 5'd19);
    run_ticks(2);
    send_item(MODE_START, 5'd25);
    run_ticks(2);
    send_item(MODE_START, 5'd26);
    send_item(MODE_TICK, 5'd0);
    send_item(MODE_START, PAT_WAITING);
    send_item(MODE_STOP, 5'd31);
    send_item(MODE_TICK, 5'd0);
    // play a non-repeating pattern through to its end
    send_item(MODE_START, PAT_BACKSPACE);
    run_ticks(402);

    // phases over all locales, the unknown ones included
    for (int ph = 0; ph < 8; ph++) begin
      write_locale(locales[ph]);
      if (ph == 1) hold_req = 400;
      // keep ticking the pattern started before the locale change
      if (ph == 5) run_ticks(20);
      budget = items_sent + 115;
      while (items_sent < budget) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(2'($urandom_range(1, 3)), 5'($urandom_range(0, 31)));
          continue;
        end
        pat = $urandom_range(0, 5) == 0 ? int'(PAT_BACKSPACE) + $urandom_range(0, 1)
                                         : $urandom_range(0, 25);
        send_item(MODE_START, 5'(pat));
        if (pat == PAT_BACKSPACE || pat == PAT_WAITING) len = $urandom_range(395, 410);
        else if ($urandom_range(0, 11) == 0) len = $urandom_range(1000, 4500);
        else len = $urandom_range(1, 30);
        if (len > budget - items_sent) len = budget - items_sent;
        if (len < 1) len = 1;
        run_ticks(len);
        if ($urandom_range(0, 3) == 0) send_item(MODE_STOP, 5'($urandom_range(0, 31)));
      end
      // locale change while playing: keep the pattern and carry on ticking
      if (ph == 4) begin
        send_item(MODE_START, PAT_RINGBACK);
        run_ticks(20);
      end
    end

    drain();
    repeat (30) @(posedge clk_i);
    $display("Run covered %0d items over 8 locale settings, %0d sounding ticks,",
             items_sent, sb.ticks_sounding);
    $display("%0d pattern ends, with random gaps and stalls on both sides.", sb.ends_seen);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
